### rtl/lds_pkg.sv
// Shared types and constants for the differential steering controller.
package lds_pkg;

	localparam int unsigned GainW    = 16;
	localparam int unsigned SpeedW   = 12;
	localparam int unsigned ErrW     = 16;
	localparam int unsigned HeadW    = 24;
	localparam int unsigned RateW    = 16;
	localparam int unsigned OutW     = 14;
	localparam int unsigned DevW     = HeadW + 1;
	localparam int unsigned SumW     = GainW + DevW;
	localparam int unsigned FracW    = 8;
	localparam int unsigned QuotW    = SumW - FracW;
	localparam int unsigned SteerW   = SpeedW + 1;
	localparam int unsigned AddrW    = 5;
	localparam int unsigned DataW    = 32;

	localparam logic signed [GainW-1:0] GainLineRst    = 16'sd256;
	localparam logic signed [GainW-1:0] GainHeadingRst = 16'sd256;
	localparam logic signed [GainW-1:0] GainRateRst    = 16'sd0;
	localparam logic [SpeedW-1:0]       SteerLimitRst  = 12'd1000;
	localparam logic [SpeedW-1:0]       BaseSpeedRst   = 12'd30;

	typedef enum logic [2:0] {
		REG_GAIN_LINE    = 3'd0,
		REG_GAIN_HEADING = 3'd1,
		REG_GAIN_RATE    = 3'd2,
		REG_STEER_LIMIT  = 3'd3,
		REG_BASE_SPEED   = 3'd4
	} lds_reg_t;

	typedef struct packed {
		logic signed [GainW-1:0] gain_line;
		logic signed [GainW-1:0] gain_heading;
		logic signed [GainW-1:0] gain_rate;
		logic [SpeedW-1:0]       steer_limit;
		logic [SpeedW-1:0]       base_speed;
	} lds_cfg_t;

endpackage

### rtl/lds_regs.sv
// APB-style configuration register file for gains, steer limit and base speed.
module lds_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lds_pkg::AddrW-1:0]       paddr,
	input  logic [lds_pkg::DataW-1:0]       pwdata,
	output logic [lds_pkg::DataW-1:0]       prdata,
	output logic                            pready,
	output lds_pkg::lds_cfg_t               cfg
);

	lds_pkg::lds_cfg_t cfg_q;
	lds_pkg::lds_reg_t reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = lds_pkg::lds_reg_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_line    <= lds_pkg::GainLineRst;
			cfg_q.gain_heading <= lds_pkg::GainHeadingRst;
			cfg_q.gain_rate    <= lds_pkg::GainRateRst;
			cfg_q.steer_limit  <= lds_pkg::SteerLimitRst;
			cfg_q.base_speed   <= lds_pkg::BaseSpeedRst;
		end else if (wr_en) begin
			case (reg_sel)
				lds_pkg::REG_GAIN_LINE:    cfg_q.gain_line    <= pwdata[15:0];
				lds_pkg::REG_GAIN_HEADING: cfg_q.gain_heading <= pwdata[15:0];
				lds_pkg::REG_GAIN_RATE:    cfg_q.gain_rate    <= pwdata[15:0];
				lds_pkg::REG_STEER_LIMIT:  cfg_q.steer_limit  <= pwdata[11:0];
				lds_pkg::REG_BASE_SPEED:   cfg_q.base_speed   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			lds_pkg::REG_GAIN_LINE:    prdata = 32'(cfg_q.gain_line);
			lds_pkg::REG_GAIN_HEADING: prdata = 32'(cfg_q.gain_heading);
			lds_pkg::REG_GAIN_RATE:    prdata = 32'(cfg_q.gain_rate);
			lds_pkg::REG_STEER_LIMIT:  prdata = {20'd0, cfg_q.steer_limit};
			lds_pkg::REG_BASE_SPEED:   prdata = {20'd0, cfg_q.base_speed};
			default:                   prdata = '0;
		endcase
	end

endmodule

### rtl/lds_core.sv
// Steering pipeline: heading hold state, gain multiply and sum, clamp and wheel speeds.
module lds_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lds_pkg::lds_cfg_t                    cfg,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 run,
	input  logic                                 lost,
	input  logic signed [lds_pkg::ErrW-1:0]      line_error,
	input  logic signed [lds_pkg::HeadW-1:0]     heading,
	input  logic signed [lds_pkg::RateW-1:0]     yaw_rate,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lds_pkg::OutW-1:0]      left_speed,
	output logic signed [lds_pkg::OutW-1:0]      right_speed
);

	logic                                en1, en2, in_acc;
	logic                                v_s1, v_s2;

	logic signed [lds_pkg::HeadW-1:0]    held_q;
	logic                                was_lost_q;

	logic signed [lds_pkg::DevW-1:0]     dev_d;
	logic signed [lds_pkg::ErrW-1:0]     err_d;
	logic                                first_lost;

	logic                                run_s1;
	logic signed [lds_pkg::ErrW-1:0]     err_s1;
	logic signed [lds_pkg::DevW-1:0]     dev_s1;
	logic signed [lds_pkg::RateW-1:0]    rate_s1;

	logic signed [2*lds_pkg::GainW-1:0]  p_line, p_rate;
	logic signed [lds_pkg::SumW-1:0]     p_head, sum_d;

	logic signed [lds_pkg::QuotW-1:0]    quot, lim_pos, lim_neg;
	logic signed [lds_pkg::SteerW-1:0]   steer;
	logic signed [lds_pkg::OutW-1:0]     base_ext, left_d, right_d;

	logic                                run_s2;
	logic signed [lds_pkg::OutW-1:0]     left_s2, right_s2;

	// advance a stage when it is empty or the next one moves
	assign en2      = !v_s2 || !out_stall;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;
	assign in_acc   = in_valid && en1;

	assign first_lost = lost && !was_lost_q;
	assign dev_d      = first_lost ? '0
	                  : lds_pkg::DevW'(heading) - lds_pkg::DevW'(held_q);
	assign err_d      = lost ? '0 : line_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			was_lost_q <= 1'b0;
		end else if (in_acc && run) begin
			if (!lost) begin
				held_q     <= heading;
				was_lost_q <= 1'b0;
			end else if (!was_lost_q) begin
				held_q     <= heading;
				was_lost_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_s1  <= run;
			err_s1  <= err_d;
			dev_s1  <= dev_d;
			rate_s1 <= yaw_rate;
		end
	end

	assign p_line = cfg.gain_line * err_s1;
	assign p_rate = cfg.gain_rate * rate_s1;
	assign p_head = cfg.gain_heading * dev_s1;
	assign sum_d  = p_head + lds_pkg::SumW'(p_line) + lds_pkg::SumW'(p_rate);

	// floor divide by 256, negate, clamp to the limit
	assign quot     = lds_pkg::QuotW'(sum_d >>> lds_pkg::FracW);
	assign lim_pos  = $signed({{(lds_pkg::QuotW-lds_pkg::SpeedW){1'b0}}, cfg.steer_limit});
	assign lim_neg  = -lim_pos;
	assign base_ext = $signed({{(lds_pkg::OutW-lds_pkg::SpeedW){1'b0}}, cfg.base_speed});

	always_comb begin
		if (quot > lim_pos) begin
			steer = -$signed({1'b0, cfg.steer_limit});
		end else if (quot < lim_neg) begin
			steer = $signed({1'b0, cfg.steer_limit});
		end else begin
			steer = lds_pkg::SteerW'(-quot);
		end
		if (run_s1) begin
			left_d  = base_ext + lds_pkg::OutW'(steer);
			right_d = base_ext - lds_pkg::OutW'(steer);
		end else begin
			left_d  = '0;
			right_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			run_s2   <= run_s1;
			left_s2  <= left_d;
			right_s2 <= right_d;
		end
	end

	assign out_valid   = v_s2;
	assign left_speed  = left_s2;
	assign right_speed = right_s2;

	a_held_follow: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && run && !lost |=> held_q == $past(heading))
		else $error("held heading did not follow heading while line seen");

	a_lost_keep: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && run && lost && was_lost_q |=> $stable(held_q))
		else $error("held heading changed during a continued loss");

	a_lost_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(was_lost_q) |-> $past(in_acc && run && lost))
		else $error("loss flag set without an accepted lost transaction");

	a_speed_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_s2 |->
		(16'(left_s2) + 16'(right_s2)) == {3'd0, cfg.base_speed, 1'b0})
		else $error("wheel speeds not symmetric about base speed");

	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_s2 |-> left_s2 == '0 && right_s2 == '0)
		else $error("nonzero speed on a stopped transaction");

endmodule

### rtl/lqr_differential_steering_top.sv
// Top level of the state-feedback differential steering controller.
// Transactions go from the input register to the result register. Throughput:
// one transaction per cycle unless stalled; an input register (heading hold)
// feeds gain multiply, sum, clamp and wheel speeds into the result register.
// Reset clears the valid bits, held heading and loss flag, and loads
// the register defaults (gains 256/256/0, steer limit 1000, base speed 30).
module lqr_differential_steering_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lds_pkg::AddrW-1:0]            paddr,
	input  logic [lds_pkg::DataW-1:0]            pwdata,
	output logic [lds_pkg::DataW-1:0]            prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 run,
	input  logic                                 lost,
	input  logic signed [lds_pkg::ErrW-1:0]      line_error,
	input  logic signed [lds_pkg::HeadW-1:0]     heading,
	input  logic signed [lds_pkg::RateW-1:0]     yaw_rate,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lds_pkg::OutW-1:0]      left_speed,
	output logic signed [lds_pkg::OutW-1:0]      right_speed
);

	lds_pkg::lds_cfg_t cfg;

	lds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lds_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.run         (run),
		.lost        (lost),
		.line_error  (line_error),
		.heading     (heading),
		.yaw_rate    (yaw_rate),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_speed  (left_speed),
		.right_speed (right_speed)
	);

endmodule

### bench/lqr_differential_steering_top_test.sv
// Self-checking testbench for the differential steering controller: directed and random ticks.
module lqr_differential_steering_top_test;

	localparam logic [2:0] RegSpareLow  = 3'd5;
	localparam logic [2:0] RegSpareHigh = 3'd7;
	localparam int         HoldCycles   = 400;
	localparam int         PhaseTicks   = 193;

	typedef struct {
		logic                             run;
		logic                             lost;
		logic signed [lds_pkg::ErrW-1:0]  line_error;
		logic signed [lds_pkg::HeadW-1:0] heading;
		logic signed [lds_pkg::RateW-1:0] yaw_rate;
	} tick_t;

	typedef struct {
		logic [lds_pkg::OutW-1:0] left;
		logic [lds_pkg::OutW-1:0] right;
	} wheel_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             psel = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite = 1'b0;
	logic [lds_pkg::AddrW-1:0]        paddr = '0;
	logic [lds_pkg::DataW-1:0]        pwdata = '0;
	logic [lds_pkg::DataW-1:0]        prdata;
	logic                             pready;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             run = 1'b0;
	logic                             lost = 1'b0;
	logic signed [lds_pkg::ErrW-1:0]  line_error = '0;
	logic signed [lds_pkg::HeadW-1:0] heading = '0;
	logic signed [lds_pkg::RateW-1:0] yaw_rate = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [lds_pkg::OutW-1:0]  left_speed;
	logic signed [lds_pkg::OutW-1:0]  right_speed;

	lqr_differential_steering_top uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.run(run), .lost(lost), .line_error(line_error), .heading(heading),
		.yaw_rate(yaw_rate),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_speed(left_speed), .right_speed(right_speed)
	);

	// controller image: registers and held state
	logic signed [lds_pkg::GainW-1:0] k_line = lds_pkg::GainLineRst;
	logic signed [lds_pkg::GainW-1:0] k_head = lds_pkg::GainHeadingRst;
	logic signed [lds_pkg::GainW-1:0] k_rate = lds_pkg::GainRateRst;
	logic [lds_pkg::SpeedW-1:0]       steer_lim = lds_pkg::SteerLimitRst;
	logic [lds_pkg::SpeedW-1:0]       base_spd = lds_pkg::BaseSpeedRst;
	logic signed [lds_pkg::HeadW-1:0] held_hdg = '0;
	logic                             line_gone = 1'b0;

	tick_t  tick_q[$];
	wheel_t speed_q[$];
	int     errors = 0;
	logic   taken = 1'b0;
	int     hold_ticket = 0;
	int     hold_served = 0;
	int     hold_left = 0;
	int     stall_mode = 0;
	int     mode_left = 0;
	int     stall_phase = 0;
	int     gap_left = 0;
	int     burst_left = 1;
	int     lost_left = 0;
	logic signed [lds_pkg::HeadW-1:0] head_walk = '0;

	always #4 clk = ~clk;

	function automatic wheel_t steer_tick(input tick_t t);
		wheel_t w;
		longint dev, total, steer, lim, left, right;
		if (!t.run) begin
			w.left = '0;
			w.right = '0;
			return w;
		end
		lim = longint'(steer_lim);
		if (!t.lost) begin
			dev = longint'(t.heading) - longint'(held_hdg);
			total = longint'(k_line) * longint'(t.line_error) + longint'(k_head) * dev
				+ longint'(k_rate) * longint'(t.yaw_rate);
			line_gone = 1'b0;
			held_hdg = t.heading;
		end else begin
			if (!line_gone) begin
				held_hdg = t.heading;
				line_gone = 1'b1;
			end
			dev = longint'(t.heading) - longint'(held_hdg);
			total = longint'(k_head) * dev + longint'(k_rate) * longint'(t.yaw_rate);
		end
		steer = -(total >>> lds_pkg::FracW);
		if (steer > lim)
			steer = lim;
		if (steer < -lim)
			steer = -lim;
		left = longint'(base_spd) + steer;
		right = longint'(base_spd) - steer;
		w.left = left[lds_pkg::OutW-1:0];
		w.right = right[lds_pkg::OutW-1:0];
		return w;
	endfunction

	function automatic tick_t mk(input int r, input int l, input int e, input int h,
		input int y);
		tick_t t;
		t.run = (r != 0);
		t.lost = (l != 0);
		t.line_error = lds_pkg::ErrW'(e);
		t.heading = lds_pkg::HeadW'(h);
		t.yaw_rate = lds_pkg::RateW'(y);
		return t;
	endfunction

	function automatic tick_t rand_tick();
		tick_t t;
		int r;
		t.run = ($urandom_range(0, 99) < 92);
		if (lost_left > 0) begin
			t.lost = 1'b1;
			lost_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			t.lost = 1'b1;
			lost_left = $urandom_range(1, 12);
		end else begin
			t.lost = ($urandom_range(0, 49) == 0);
		end
		if ($urandom_range(0, 9) < 7)
			t.line_error = lds_pkg::ErrW'(int'($urandom_range(0, 400)) - 200);
		else
			t.line_error = lds_pkg::ErrW'($urandom());
		r = $urandom_range(0, 99);
		if (r < 85)
			head_walk = head_walk + lds_pkg::HeadW'(int'($urandom_range(0, 600)) - 300);
		else if (r < 95)
			head_walk = lds_pkg::HeadW'($urandom());
		else
			head_walk = $urandom_range(0, 1) ? {1'b0, {(lds_pkg::HeadW-1){1'b1}}}
				: {1'b1, {(lds_pkg::HeadW-1){1'b0}}};
		t.heading = head_walk;
		if ($urandom_range(0, 9) < 7)
			t.yaw_rate = lds_pkg::RateW'(int'($urandom_range(0, 2000)) - 1000);
		else
			t.yaw_rate = lds_pkg::RateW'($urandom());
		return t;
	endfunction

	function automatic logic [lds_pkg::DataW-1:0] rand_gain();
		int r;
		r = $urandom_range(0, 3);
		case (r)
			0: return {16'($urandom_range(0, 65535)),
				16'(int'($urandom_range(0, 1024)) - 512)};
			1: return $urandom();
			default: return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 600))};
		endcase
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [lds_pkg::DataW-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			lds_pkg::REG_GAIN_LINE:    k_line = value[lds_pkg::GainW-1:0];
			lds_pkg::REG_GAIN_HEADING: k_head = value[lds_pkg::GainW-1:0];
			lds_pkg::REG_GAIN_RATE:    k_rate = value[lds_pkg::GainW-1:0];
			lds_pkg::REG_STEER_LIMIT:  steer_lim = value[lds_pkg::SpeedW-1:0];
			lds_pkg::REG_BASE_SPEED:   base_spd = value[lds_pkg::SpeedW-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (tick_q.size() != 0 || speed_q.size() != 0 || in_valid);
		repeat (4) @(negedge clk);
	endtask

	// sender: bursts with random gaps
	always @(negedge clk) begin
		tick_t t;
		if (arst_n && (!in_valid || taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				t = tick_q.pop_front();
				run <= t.run;
				lost <= t.lost;
				line_error <= t.line_error;
				heading <= t.heading;
				yaw_rate <= t.yaw_rate;
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		stall_phase++;
		if (hold_served != hold_ticket) begin
			hold_served = hold_ticket;
			hold_left = HoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(5, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= (stall_phase % 3 == 0);
				default: out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		tick_t  cur;
		wheel_t want;
		taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			cur.run = run;
			cur.lost = lost;
			cur.line_error = line_error;
			cur.heading = heading;
			cur.yaw_rate = yaw_rate;
			speed_q.push_back(steer_tick(cur));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (speed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output transaction: left %0d right %0d",
						left_speed, right_speed);
			end else begin
				want = speed_q.pop_front();
				if (left_speed !== want.left || right_speed !== want.right) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
							$signed(want.left), left_speed, $signed(want.right), right_speed);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		tick_q.push_back(mk(0, 0, 32767, 8388607, 32767));
		tick_q.push_back(mk(0, 1, -32768, -8388608, -32768));
		tick_q.push_back(mk(1, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 0, 100, 0, 0));
		tick_q.push_back(mk(1, 0, 32767, 0, 0));
		tick_q.push_back(mk(1, 0, -32768, 0, 0));
		tick_q.push_back(mk(1, 0, 0, 8388607, 0));
		tick_q.push_back(mk(1, 0, 0, -8388608, 0));
		tick_q.push_back(mk(1, 1, 500, 1000, 0));
		tick_q.push_back(mk(1, 1, 500, 1300, 0));
		tick_q.push_back(mk(0, 1, 0, 5000, 0));
		tick_q.push_back(mk(1, 1, 0, 1500, 0));
		tick_q.push_back(mk(1, 0, -7, 1600, 0));
		tick_q.push_back(mk(1, 0, -1, 1600, 0));
		drain();

		reg_write(lds_pkg::REG_GAIN_LINE, 32'hA5A5_7FFF);
		reg_write(lds_pkg::REG_GAIN_HEADING, 32'h5A5A_8000);
		reg_write(lds_pkg::REG_GAIN_RATE, 32'hFFFF_0001);
		reg_write(lds_pkg::REG_STEER_LIMIT, 32'hFFFF_FFFF);
		reg_write(lds_pkg::REG_BASE_SPEED, 32'h0000_0FFF);
		tick_q.push_back(mk(1, 0, 1, 1600, 0));
		tick_q.push_back(mk(1, 0, -1, 1600, 0));
		tick_q.push_back(mk(1, 0, 0, 1600, 255));
		tick_q.push_back(mk(1, 0, 0, 1600, -1));
		tick_q.push_back(mk(1, 0, 32767, -8388608, 32767));
		tick_q.push_back(mk(1, 0, -32768, 8388607, -32768));
		tick_q.push_back(mk(1, 1, 0, 0, -32768));
		tick_q.push_back(mk(1, 1, 0, 8388607, 32767));
		drain();

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin
					reg_write(lds_pkg::REG_STEER_LIMIT, 32'h0000_0000);
					reg_write(lds_pkg::REG_BASE_SPEED, $urandom());
					reg_write(lds_pkg::REG_GAIN_LINE, rand_gain());
				end
				1: begin
					reg_write(lds_pkg::REG_GAIN_LINE, 32'h0000_7FFF);
					reg_write(lds_pkg::REG_GAIN_HEADING, 32'h0000_7FFF);
					reg_write(lds_pkg::REG_GAIN_RATE, 32'h0000_7FFF);
					reg_write(lds_pkg::REG_STEER_LIMIT, 32'h0000_0FFF);
					reg_write(lds_pkg::REG_BASE_SPEED, 32'h0000_0000);
				end
				2: begin
					reg_write(lds_pkg::REG_GAIN_LINE, 32'hFFFF_8000);
					reg_write(lds_pkg::REG_GAIN_HEADING, 32'h0000_8000);
					reg_write(lds_pkg::REG_GAIN_RATE, 32'hFFFF_8000);
					reg_write(RegSpareLow, 32'hFFFF_FFFF);
					reg_write(RegSpareHigh, $urandom());
				end
				3: begin
					reg_write(lds_pkg::REG_GAIN_LINE, 32'(lds_pkg::GainLineRst));
					reg_write(lds_pkg::REG_GAIN_HEADING, 32'(lds_pkg::GainHeadingRst));
					reg_write(lds_pkg::REG_GAIN_RATE, 32'(lds_pkg::GainRateRst));
					reg_write(lds_pkg::REG_STEER_LIMIT, 32'(lds_pkg::SteerLimitRst));
					reg_write(lds_pkg::REG_BASE_SPEED, 32'(lds_pkg::BaseSpeedRst));
				end
				default: begin
					reg_write(lds_pkg::REG_GAIN_LINE, rand_gain());
					reg_write(lds_pkg::REG_GAIN_HEADING, rand_gain());
					reg_write(lds_pkg::REG_GAIN_RATE, rand_gain());
					reg_write(lds_pkg::REG_STEER_LIMIT, ($urandom_range(0, 2) == 0)
						? $urandom() : 32'($urandom_range(0, 600)));
					reg_write(lds_pkg::REG_BASE_SPEED, $urandom());
					if (p == 5)
						reg_write(RegSpareLow, $urandom());
				end
			endcase
			for (int i = 0; i < PhaseTicks; i++)
				tick_q.push_back(rand_tick());
			if (p == 3 || p == 7)
				hold_ticket++;
			drain();
		end

		repeat (12) @(posedge clk);
		if (errors == 0 && speed_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
